FILE: rtl/lbfp_pkg.sv
`default_nettype none

package lbfp_pkg;

  // opcodes of an input word
  localparam logic OP_APPEND = 1'b0;
  localparam logic OP_FLUSH  = 1'b1;

  // packet limits
  localparam int PACKET_CAPACITY = 64;
  localparam int MAX_FIELD_BITS  = 32;

  // the data path never takes more than 32 value bits
  localparam int FIELD_LIMIT = (MAX_FIELD_BITS < 32) ? MAX_FIELD_BITS : 32;

  localparam int ACC_W = 40;  // 7 held bits plus 32 value bits, rounded to bytes
  localparam int TOT_W = 6;   // 0..39 bits in the accumulator
  localparam int LEN_W = 7;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SHIFT = 3'b010,
    ST_FLUSH = 3'b100
  } state_t;

endpackage

`default_nettype wire

FILE: rtl/lsb_first_bit_field_packer.sv
`default_nettype none

// channel  ports                                                   direction
// in       in_valid in_stall in_opcode in_field_value in_field_width  input
// out      out_valid out_stall out_byte out_is_last                   output
//          out_packet_length out_overflowed
//
// an append loads the accumulator, then the byte shifter sends out each full byte
// (floor((held bits + width) / 8), up to 4), dropping it if the packet is full, and
// then closes; a zero-width append leaves the sequencer idle, and a flush emits the final byte.
// in_stall is high for every cycle after acceptance until the sequencer is idle.
// a word waiting in the output register under out_stall holds the shifter.
// rst_n is synchronous and clears the packet state and the output valid.

module lsb_first_bit_field_packer (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_opcode,
  input  wire logic [31:0] in_field_value,
  input  wire logic [5:0]  in_field_width,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_byte,
  output logic             out_is_last,
  output logic [6:0]       out_packet_length,
  output logic             out_overflowed
);

  localparam logic [lbfp_pkg::LEN_W-1:0] ROOM_LIMIT =
    lbfp_pkg::LEN_W'(lbfp_pkg::PACKET_CAPACITY - 1);
  localparam logic [5:0] WIDTH_LIMIT = 6'(lbfp_pkg::FIELD_LIMIT);

  lbfp_pkg::state_t state_r, state_nxt;

  logic [lbfp_pkg::ACC_W-1:0] acc_r, acc_nxt;
  logic [lbfp_pkg::TOT_W-1:0] total_r, total_nxt;
  logic [7:0]                 partial_r, partial_nxt;
  logic [2:0]                 bits_used_r, bits_used_nxt;
  logic [lbfp_pkg::LEN_W-1:0] emitted_r, emitted_nxt;
  logic                       ovf_r, ovf_nxt;

  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_byte_r, out_byte_nxt;
  logic       out_last_r, out_last_nxt;
  logic [6:0] out_len_r, out_len_nxt;
  logic       out_ovf_r, out_ovf_nxt;

  logic        in_take;
  logic        out_free;
  logic [5:0]  width_c;
  logic [31:0] mask_c;
  logic [31:0] value_c;
  logic        has_room;

  assign in_stall  = (state_r != lbfp_pkg::ST_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign has_room  = (emitted_r < ROOM_LIMIT);

  always_comb begin
    width_c = (in_field_width > WIDTH_LIMIT) ? WIDTH_LIMIT : in_field_width;
    if (width_c[5]) begin
      mask_c = 32'hffff_ffff;
    end else begin
      mask_c = (32'd1 << width_c[4:0]) - 32'd1;
    end
    value_c = in_field_value & mask_c;
  end

  always_comb begin
    state_nxt     = state_r;
    acc_nxt       = acc_r;
    total_nxt     = total_r;
    partial_nxt   = partial_r;
    bits_used_nxt = bits_used_r;
    emitted_nxt   = emitted_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    out_len_nxt   = out_len_r;
    out_ovf_nxt   = out_ovf_r;

    case (state_r)
      lbfp_pkg::ST_IDLE: begin
        if (in_take) begin
          if (in_opcode == lbfp_pkg::OP_FLUSH) begin
            state_nxt = lbfp_pkg::ST_FLUSH;
          end else if (width_c != 6'd0) begin
            // new bits go straight above the held ones
            acc_nxt   = {32'd0, partial_r} |
                        ({8'd0, value_c} << bits_used_r);
            total_nxt = {3'd0, bits_used_r} + width_c;
            state_nxt = lbfp_pkg::ST_SHIFT;
          end
        end
      end
      lbfp_pkg::ST_SHIFT: begin
        if (total_r >= 6'd8) begin
          if (!has_room) begin
            // full packet: the word is dropped
            ovf_nxt   = 1'b1;
            acc_nxt   = acc_r >> 8;
            total_nxt = total_r - 6'd8;
          end else if (out_free) begin
            out_valid_nxt = 1'b1;
            out_byte_nxt  = acc_r[7:0];
            out_last_nxt  = 1'b0;
            out_len_nxt   = 7'd0;
            out_ovf_nxt   = ovf_r;
            emitted_nxt   = emitted_r + 7'd1;
            acc_nxt       = acc_r >> 8;
            total_nxt     = total_r - 6'd8;
          end
        end else begin
          partial_nxt   = acc_r[7:0];
          bits_used_nxt = total_r[2:0];
          state_nxt     = lbfp_pkg::ST_IDLE;
        end
      end
      lbfp_pkg::ST_FLUSH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = partial_r;
          out_last_nxt  = 1'b1;
          out_len_nxt   = emitted_r + 7'd1;
          out_ovf_nxt   = ovf_r;
          partial_nxt   = 8'd0;
          bits_used_nxt = 3'd0;
          emitted_nxt   = 7'd0;
          ovf_nxt       = 1'b0;
          state_nxt     = lbfp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = lbfp_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lbfp_pkg::ST_IDLE;
      partial_r   <= 8'd0;
      bits_used_r <= 3'd0;
      emitted_r   <= 7'd0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      partial_r   <= partial_nxt;
      bits_used_r <= bits_used_nxt;
      emitted_r   <= emitted_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r      <= acc_nxt;
    total_r    <= total_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
    out_len_r  <= out_len_nxt;
    out_ovf_r  <= out_ovf_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_byte          = out_byte_r;
  assign out_is_last       = out_last_r;
  assign out_packet_length = out_len_r;
  assign out_overflowed    = out_ovf_r;

  a_room_bound: assert property (@(posedge clk) disable iff (!rst_n)
    emitted_r <= ROOM_LIMIT)
    else $error("emitted count beyond packet room");

  a_last_has_length: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_last_r |-> out_len_r != 7'd0)
    else $error("final word without packet length");

  a_mid_no_length: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_last_r |-> out_len_r == 7'd0)
    else $error("packet length on a word that is not final");

  a_shift_closes: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == lbfp_pkg::ST_SHIFT && total_r < 6'd8 |=> state_r == lbfp_pkg::ST_IDLE)
    else $error("shifter did not close with fewer than a word of bits");

  a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == lbfp_pkg::ST_FLUSH && out_free |=>
      emitted_r == 7'd0 && bits_used_r == 3'd0 && !ovf_r)
    else $error("flush left packet state behind");

endmodule

`default_nettype wire

FILE: sim/tb_lsb_first_bit_field_packer.sv
module tb_lsb_first_bit_field_packer;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 8;
  localparam int IDLE_PCT = 32;

  typedef struct packed {
    logic [7:0]                 data;
    logic                       last;
    logic [lbfp_pkg::LEN_W-1:0] pkt_len;
    logic                       ovf;
  } packed_byte_t;

  bit clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_opcode = lbfp_pkg::OP_APPEND;
  logic [31:0] in_field_value = '0;
  logic [5:0] in_field_width = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [7:0] out_byte;
  logic out_is_last;
  logic [6:0] out_packet_length;
  logic out_overflowed;

  // expected bytes, oldest first
  packed_byte_t pending_bytes[$];

  // predicted packer state
  logic [7:0] held_bits;
  int held_count;
  int packet_bytes;
  logic dropped;

  int errors;
  int words_sent;
  int cycle_count;
  int hold_cycles;
  bit no_idle;

  lsb_first_bit_field_packer dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_opcode(in_opcode),
    .in_field_value(in_field_value),
    .in_field_width(in_field_width),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_byte(out_byte),
    .out_is_last(out_is_last),
    .out_packet_length(out_packet_length),
    .out_overflowed(out_overflowed)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_lsb_first_bit_field_packer: FAIL");
      $finish;
    end
  end

  task automatic clear_packet();
    held_bits = '0;
    held_count = 0;
    packet_bytes = 0;
    dropped = 1'b0;
  endtask

  // works out the bytes that one accepted word releases
  task automatic pack_word(input logic op, input logic [31:0] val, input logic [5:0] width);
    int w;
    int total;
    logic [63:0] acc;
    logic [63:0] mask;
    packed_byte_t exp_byte;
    if (op == lbfp_pkg::OP_FLUSH) begin
      exp_byte = '{data: held_bits, last: 1'b1,
                   pkt_len: lbfp_pkg::LEN_W'(packet_bytes + 1), ovf: dropped};
      pending_bytes.push_back(exp_byte);
      clear_packet();
      return;
    end
    w = int'(width);
    if (w > lbfp_pkg::MAX_FIELD_BITS) w = lbfp_pkg::MAX_FIELD_BITS;
    if (w > 32) w = 32;
    if (w == 0) return;
    mask = (64'd1 << w) - 64'd1;
    acc = {56'd0, held_bits} | ((({32'd0, val}) & mask) << held_count);
    total = held_count + w;
    while (total >= 8) begin
      if (packet_bytes + 1 < lbfp_pkg::PACKET_CAPACITY) begin
        packet_bytes++;
        exp_byte = '{data: acc[7:0], last: 1'b0, pkt_len: '0, ovf: dropped};
        pending_bytes.push_back(exp_byte);
      end else begin
        dropped = 1'b1;
      end
      acc = acc >> 8;
      total -= 8;
    end
    held_bits = acc[7:0];
    held_count = total % 8;
  endtask

  task automatic send_word(input logic op, input logic [31:0] val, input logic [5:0] width);
    @(negedge clk);
    if (!no_idle) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_field_value <= val;
    in_field_width <= width;
    do @(posedge clk); while (in_stall !== 1'b0);
    pack_word(op, val, width);
    words_sent++;
  endtask

  task automatic send_random_field();
    int r;
    logic [5:0] width;
    r = $urandom_range(99);
    if (r < 6) width = 6'd0;
    else if (r < 14) width = 6'($urandom_range(63, 33));
    else width = 6'($urandom_range(32, 1));
    send_word(lbfp_pkg::OP_APPEND, $urandom(), width);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
    // a zero-width append leaves nothing to wait for
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic test_basic_fields();
    send_word(lbfp_pkg::OP_APPEND, 32'h0000_00a5, 6'd8);
    send_word(lbfp_pkg::OP_APPEND, 32'h0000_0001, 6'd1);
    // stray bits above the width must not leak
    send_word(lbfp_pkg::OP_APPEND, 32'hdead_beef, 6'd5);
    send_word(lbfp_pkg::OP_APPEND, 32'hffff_ffff, 6'd0);
    send_word(lbfp_pkg::OP_APPEND, 32'hffff_ffff, 6'd32);
    send_word(lbfp_pkg::OP_FLUSH, 32'h0000_0000, 6'd0);
    wait_drained();
  endtask

  task automatic test_empty_flush();
    send_word(lbfp_pkg::OP_FLUSH, 32'hffff_ffff, 6'd63);
    wait_drained();
  endtask

  task automatic test_overflow();
    // 64 full bytes: the last one is dropped, then flush reports the drop
    for (int i = 0; i < 16; i++) begin
      case (i % 4)
        0: send_word(lbfp_pkg::OP_APPEND, 32'hffff_ffff, 6'd32);
        1: send_word(lbfp_pkg::OP_APPEND, 32'h0000_0000, 6'd63);
        2: send_word(lbfp_pkg::OP_APPEND, $urandom(), 6'd40);
        default: send_word(lbfp_pkg::OP_APPEND, $urandom(), 6'd33);
      endcase
    end
    send_word(lbfp_pkg::OP_FLUSH, $urandom(), 6'($urandom_range(63)));
    wait_drained();
  endtask

  task automatic test_backpressure();
    @(posedge clk);
    hold_cycles = 150;
    for (int i = 0; i < 10; i++) send_word(lbfp_pkg::OP_APPEND, $urandom(), 6'd32);
    send_word(lbfp_pkg::OP_FLUSH, $urandom(), 6'($urandom_range(63)));
    wait_drained();
  endtask

  task automatic test_steady_stream();
    no_idle = 1'b1;
    for (int i = 0; i < 40; i++) begin
      if ($urandom_range(99) < 15) begin
        send_word(lbfp_pkg::OP_FLUSH, $urandom(), 6'($urandom_range(63)));
      end else begin
        send_random_field();
      end
    end
    send_word(lbfp_pkg::OP_FLUSH, $urandom(), 6'($urandom_range(63)));
    no_idle = 1'b0;
    wait_drained();
  endtask

  task automatic test_random();
    int target;
    int n;
    int kind;
    target = words_sent + 170;
    while (words_sent < target) begin
      kind = $urandom_range(99);
      if (kind < 70) begin
        n = $urandom_range(10, 1);
        repeat (n) send_random_field();
        send_word(lbfp_pkg::OP_FLUSH, $urandom(), 6'($urandom_range(63)));
      end else if (kind < 80) begin
        // long packet that runs past capacity
        n = $urandom_range(22, 17);
        repeat (n) send_word(lbfp_pkg::OP_APPEND, $urandom(), 6'($urandom_range(63, 32)));
        send_word(lbfp_pkg::OP_FLUSH, $urandom(), 6'($urandom_range(63)));
      end else begin
        n = $urandom_range(6, 1);
        repeat (n) send_word(1'($urandom_range(1)), $urandom(), 6'($urandom_range(63)));
      end
    end
    wait_drained();
  endtask

  // receiver: random stalls, plus a counted hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_stall <= 1'b1;
        hold_cycles--;
      end else begin
        out_stall <= (!no_idle && $urandom_range(99) < IDLE_PCT);
      end
    end
  end

  always @(posedge clk) begin
    packed_byte_t exp_byte;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_bytes.size() == 0) begin
        $error("unexpected word: out_byte %0h is_last %0b", out_byte, out_is_last);
        errors++;
      end else begin
        exp_byte = pending_bytes.pop_front();
        if (out_byte !== exp_byte.data) begin
          $error("out_byte expected %0h actual %0h", exp_byte.data, out_byte);
          errors++;
        end
        if (out_is_last !== exp_byte.last) begin
          $error("out_is_last expected %0b actual %0b", exp_byte.last, out_is_last);
          errors++;
        end
        if (out_packet_length !== exp_byte.pkt_len) begin
          $error("out_packet_length expected %0d actual %0d", exp_byte.pkt_len,
                 out_packet_length);
          errors++;
        end
        if (out_overflowed !== exp_byte.ovf) begin
          $error("out_overflowed expected %0b actual %0b", exp_byte.ovf, out_overflowed);
          errors++;
        end
      end
    end
  end

  initial begin
    clear_packet();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_basic_fields();
    test_empty_flush();
    test_overflow();
    test_backpressure();
    test_steady_stream();
    test_random();
    repeat (16) @(posedge clk);
    if (errors == 0 && pending_bytes.size() == 0) begin
      $display("tb_lsb_first_bit_field_packer: PASS");
    end else begin
      $display("tb_lsb_first_bit_field_packer: FAIL");
    end
    $finish;
  end

endmodule
